[src/wrcm_pkg.sv]
package wrcm_pkg;

  // Channel geometry
  localparam int NUM_CHANNELS = 14;
  localparam int CH_W         = 4;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Field widths
  localparam int OP_W      = 2;
  localparam int MAC_W     = 48;
  localparam int RSSI_W    = 8;
  localparam int SUBTYPE_W = 4;
  localparam int COUNT_W   = 32;
  localparam int SUM_W     = 40;
  localparam int AVG_W     = 8;
  localparam int LVL_W     = 7;
  localparam int CFG_IDX_W = 2;

  // The divider retires one dividend bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Level limits in dBm
  localparam logic signed [AVG_W-1:0] LVL_MIN  = -8'sd90;
  localparam logic signed [AVG_W-1:0] LVL_MAX  = -8'sd20;
  localparam logic signed [AVG_W-1:0] AVG_NONE = -8'sd100;
  localparam logic [LVL_W-1:0]        LVL_TOP  = 7'd70;

  // Management subtypes that pass in deauth-only mode
  localparam logic [SUBTYPE_W-1:0] SUBTYPE_DISASSOC = 4'd10;
  localparam logic [SUBTYPE_W-1:0] SUBTYPE_DEAUTH   = 4'd12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAUTH_ONLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CHANNEL = 2'd2;

  // Operation codes of an input transaction
  typedef enum logic [OP_W-1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT,
    ST_TICK
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

  // Level table write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [LVL_W-1:0] data;
  } lvl_wr_t;

  // floor(9*v/10): 9*v stays below 1029, where *205>>11 is exact.
  function automatic logic [LVL_W-1:0] fade(input logic [LVL_W-1:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd1845;
    return p[LVL_W+10:11];
  endfunction

  // Clamp an average to LVL_MIN..LVL_MAX and offset it to 0..70.
  function automatic logic [LVL_W-1:0] level_of(input logic signed [AVG_W-1:0] a);
    logic signed [AVG_W-1:0] d;
    d = a - LVL_MIN;
    if (a < LVL_MIN) begin
      return '0;
    end else if (a > LVL_MAX) begin
      return LVL_TOP;
    end
    return d[LVL_W-1:0];
  endfunction

endpackage

[src/wrcm_ifs.sv]
interface wrcm_pkt_if;
  logic                                 valid;
  logic                                 ready;
  logic [wrcm_pkg::OP_W-1:0]            op;
  logic [wrcm_pkg::CH_W-1:0]            channel;
  logic signed [wrcm_pkg::RSSI_W-1:0]   rssi;
  logic [wrcm_pkg::MAC_W-1:0]           source_mac;
  logic                                 is_management;
  logic [wrcm_pkg::SUBTYPE_W-1:0]       frame_subtype;

  modport source (output valid, op, channel, rssi, source_mac, is_management,
                  frame_subtype, input ready);
  modport sink (input valid, op, channel, rssi, source_mac, is_management,
                frame_subtype, output ready);
endinterface

interface wrcm_res_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic                                accepted;
  logic [wrcm_pkg::COUNT_W-1:0]        packet_total;
  logic signed [wrcm_pkg::AVG_W-1:0]   average_rssi;
  logic [wrcm_pkg::CH_W-1:0]           hist_channel;
  logic [wrcm_pkg::LVL_W-1:0]          hist_level;
  logic                                last;

  modport source (output valid, kind, accepted, packet_total, average_rssi,
                  hist_channel, hist_level, last, input ready);
  modport sink (input valid, kind, accepted, packet_total, average_rssi,
                hist_channel, hist_level, last, output ready);
endinterface

[src/wrcm_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module wrcm_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wrcm_pkg::div_req_t req_i,
  output wrcm_pkg::div_rsp_t rsp_o
);

  logic [wrcm_pkg::COUNT_W-1:0]   rem_q, rem_d;
  logic [wrcm_pkg::SUM_W-1:0]     quo_q, quo_d;
  logic [wrcm_pkg::COUNT_W-1:0]   den_q, den_d;
  logic [wrcm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [wrcm_pkg::COUNT_W:0]     trial;
  logic [wrcm_pkg::COUNT_W:0]     diff;
  logic                           fits;

  assign trial = {rem_q, quo_q[wrcm_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = !diff[wrcm_pkg::COUNT_W];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = wrcm_pkg::DIV_CNT_W'(wrcm_pkg::DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[wrcm_pkg::COUNT_W-1:0] : trial[wrcm_pkg::COUNT_W-1:0];
      quo_d = {quo_q[wrcm_pkg::SUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wrcm_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  // The quotient of an average never exceeds 128, so its low byte is enough.
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[wrcm_pkg::AVG_W-1:0];

endmodule

[src/wrcm_level_table.sv]
// Per-channel level registers, cleared by reset, one write and one read port.
module wrcm_level_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wrcm_pkg::lvl_wr_t            wr_i,
  input  logic [wrcm_pkg::IDX_W-1:0]   rd_addr_i,
  output logic [wrcm_pkg::LVL_W-1:0]   rd_data_o
);

  logic [wrcm_pkg::LVL_W-1:0] lvl_q [wrcm_pkg::NUM_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wrcm_pkg::NUM_CHANNELS; i++) begin
        lvl_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      lvl_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = lvl_q[rd_addr_i];

endmodule

[src/wifi_rssi_channel_monitor_unit.sv]
// An accepted packet is answered after a load step, the divider's steps, the divider's
// done and the output register; a dropped packet or a statistics clear goes straight to
// the output register; a refresh tick emits one histogram entry a cycle, NUM_CHANNELS in
// all, while the receiver keeps up. One item is in work at a time: the next is taken only
// once the last one's result, or last histogram entry, is in the output register.
// Reset (rst_ni low, asynchronous) resets the state, statistics, settings and level table.
module wifi_rssi_channel_monitor_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wrcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wrcm_pkg::MAC_W-1:0]       cfg_data_i,
  wrcm_pkt_if.sink                         item_i,
  wrcm_res_if.source                       result_o
);

  // Configuration registers.
  logic [wrcm_pkg::MAC_W-1:0] target_mac_q;
  logic                       deauth_only_q;
  logic                       auto_channel_q;

  // Statistics. The sum is never positive, and since every counted sample is at
  // least -128 and the count saturates below 2^32, it can never reach -2^39.
  logic [wrcm_pkg::COUNT_W-1:0]      count_q;
  logic signed [wrcm_pkg::SUM_W-1:0] sum_q;
  logic signed [wrcm_pkg::AVG_W-1:0] avg_q;

  // Per-transaction working registers.
  wrcm_pkg::state_e            state_q, state_d;
  logic                        acc_q;
  logic [wrcm_pkg::CH_W-1:0]   ch_q;
  logic [wrcm_pkg::IDX_W-1:0]  idx_q;

  // Output register.
  logic                              res_valid_q;
  logic                              res_kind_q;
  logic                              res_acc_q;
  logic [wrcm_pkg::COUNT_W-1:0]      res_total_q;
  logic signed [wrcm_pkg::AVG_W-1:0] res_avg_q;
  logic [wrcm_pkg::CH_W-1:0]         res_ch_q;
  logic [wrcm_pkg::LVL_W-1:0]        res_lvl_q;
  logic                              res_last_q;

  // Control.
  logic                              item_take;
  logic                              out_free;
  logic                              pass;
  logic                              src_ok;
  logic                              type_ok;
  logic                              idx_last;
  logic                              stats_add;
  logic                              stats_clear;
  logic                              load_pkt;
  logic                              load_hist;
  logic signed [wrcm_pkg::AVG_W-1:0] div_avg;
  logic [wrcm_pkg::LVL_W-1:0]        lvl_rd;
  logic [wrcm_pkg::LVL_W-1:0]        lvl_faded;
  wrcm_pkg::div_req_t                div_req;
  wrcm_pkg::div_rsp_t                div_rsp;
  wrcm_pkg::lvl_wr_t                 lvl_wr;

  // Packet filter, evaluated on the transaction as it is taken.
  assign src_ok  = (target_mac_q == '0) || (item_i.source_mac == target_mac_q);
  assign type_ok = !deauth_only_q ||
                   (item_i.is_management &&
                    ((item_i.frame_subtype == wrcm_pkg::SUBTYPE_DISASSOC) ||
                     (item_i.frame_subtype == wrcm_pkg::SUBTYPE_DEAUTH)));
  assign pass    = (item_i.channel != '0) &&
                   (item_i.rssi[wrcm_pkg::RSSI_W-1] || (item_i.rssi == '0)) &&
                   src_ok && type_ok;

  assign item_take = item_i.valid && (state_q == wrcm_pkg::ST_IDLE);
  assign out_free  = !res_valid_q || result_o.ready;
  assign idx_last  = (idx_q == wrcm_pkg::IDX_W'(wrcm_pkg::NUM_CHANNELS - 1));
  assign lvl_faded = wrcm_pkg::fade(lvl_rd);

  // The divider works on magnitudes; the average is the negated quotient.
  assign div_avg = -$signed(div_rsp.quotient);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrcm_pkg::ST_IDLE: begin
        if (item_take) begin
          case (item_i.op)
            wrcm_pkg::OP_PACKET: state_d = pass ? wrcm_pkg::ST_LOAD : wrcm_pkg::ST_EMIT;
            wrcm_pkg::OP_TICK:   state_d = wrcm_pkg::ST_TICK;
            wrcm_pkg::OP_CLEAR:  state_d = wrcm_pkg::ST_EMIT;
            default:             state_d = wrcm_pkg::ST_IDLE;
          endcase
        end
      end
      wrcm_pkg::ST_LOAD: state_d = wrcm_pkg::ST_DIV;
      wrcm_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = wrcm_pkg::ST_EMIT;
        end
      end
      wrcm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = wrcm_pkg::ST_IDLE;
        end
      end
      wrcm_pkg::ST_TICK: begin
        if (out_free && idx_last) begin
          state_d = wrcm_pkg::ST_IDLE;
        end
      end
      default: state_d = wrcm_pkg::ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    item_i.ready     = 1'b0;
    stats_add        = 1'b0;
    stats_clear      = 1'b0;
    load_pkt         = 1'b0;
    load_hist        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = -sum_q;
    div_req.divisor  = count_q;
    lvl_wr.en        = 1'b0;
    lvl_wr.addr      = idx_q;
    lvl_wr.data      = lvl_faded;
    case (state_q)
      wrcm_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_take) begin
          stats_add   = (item_i.op == wrcm_pkg::OP_PACKET) && pass &&
                        (count_q != '1);
          stats_clear = (item_i.op == wrcm_pkg::OP_CLEAR);
        end
      end
      wrcm_pkg::ST_LOAD: div_req.start = 1'b1;
      wrcm_pkg::ST_DIV: begin
        // A channel beyond the table is counted but leaves no level behind.
        if (div_rsp.done &&
            (ch_q <= wrcm_pkg::CH_W'(wrcm_pkg::NUM_CHANNELS))) begin
          lvl_wr.en   = 1'b1;
          lvl_wr.addr = wrcm_pkg::IDX_W'(ch_q - 1'b1);
          lvl_wr.data = wrcm_pkg::level_of(div_avg);
        end
      end
      wrcm_pkg::ST_EMIT: load_pkt = out_free;
      wrcm_pkg::ST_TICK: begin
        if (out_free) begin
          load_hist   = 1'b1;
          lvl_wr.en   = 1'b1;
          stats_clear = idx_last && !auto_channel_q;
        end
      end
      default: ;
    endcase
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_mac_q   <= '0;
      deauth_only_q  <= 1'b0;
      auto_channel_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wrcm_pkg::CFG_TARGET_MAC:   target_mac_q   <= cfg_data_i;
        wrcm_pkg::CFG_DEAUTH_ONLY:  deauth_only_q  <= cfg_data_i[0];
        wrcm_pkg::CFG_AUTO_CHANNEL: auto_channel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer state, statistics and tick index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrcm_pkg::ST_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      avg_q   <= wrcm_pkg::AVG_NONE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (stats_clear) begin
        count_q <= '0;
        sum_q   <= '0;
        avg_q   <= wrcm_pkg::AVG_NONE;
      end else begin
        if (stats_add) begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + wrcm_pkg::SUM_W'(item_i.rssi);
        end
        if ((state_q == wrcm_pkg::ST_DIV) && div_rsp.done) begin
          avg_q <= div_avg;
        end
      end
      // The index wraps after the last channel so it always addresses the table.
      if (item_take) begin
        idx_q <= '0;
      end else if (load_hist) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Fields of the transaction in work.
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      acc_q <= (item_i.op == wrcm_pkg::OP_PACKET) && pass;
      ch_q  <= item_i.channel;
    end
  end

  // Output register: a result waits here while the next transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_pkt || load_hist) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pkt) begin
      res_kind_q  <= 1'b0;
      res_acc_q   <= acc_q;
      res_total_q <= count_q;
      res_avg_q   <= avg_q;
      res_ch_q    <= '0;
      res_lvl_q   <= '0;
      res_last_q  <= 1'b1;
    end else if (load_hist) begin
      res_kind_q  <= 1'b1;
      res_acc_q   <= 1'b0;
      res_total_q <= '0;
      res_avg_q   <= '0;
      res_ch_q    <= wrcm_pkg::CH_W'(idx_q) + 1'b1;
      res_lvl_q   <= lvl_faded;
      res_last_q  <= idx_last;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.kind         = res_kind_q;
  assign result_o.accepted     = res_acc_q;
  assign result_o.packet_total = res_total_q;
  assign result_o.average_rssi = res_avg_q;
  assign result_o.hist_channel = res_ch_q;
  assign result_o.hist_level   = res_lvl_q;
  assign result_o.last         = res_last_q;

  wrcm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wrcm_level_table u_level_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (lvl_wr),
    .rd_addr_i (idx_q),
    .rd_data_o (lvl_rd)
  );

endmodule

[test/wrcm_result_checker.sv]
module wrcm_result_checker
  import wrcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MAC_W-1:0]     cfg_data_i,
  wrcm_pkt_if                  item_mon,
  wrcm_res_if                  result_mon,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);

  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic                    kind;
    logic                    accepted;
    logic [COUNT_W-1:0]      total;
    logic signed [AVG_W-1:0] avg;
    logic [CH_W-1:0]         ch;
    logic [LVL_W-1:0]        lvl;
    logic                    last;
  } report_t;

  report_t pending_reports[$];
  int unsigned mismatch_total = 0;

  // Shadow copy of the monitor's registers and statistics.
  logic [MAC_W-1:0]        mac_filter;
  logic                    deauth_mode;
  logic                    scan_mode;
  logic [COUNT_W-1:0]      pkt_count;
  logic signed [SUM_W-1:0] rssi_sum;
  logic signed [AVG_W-1:0] mean_level;
  logic [LVL_W-1:0]        levels [NUM_CHANNELS];

  function automatic void restart_stats();
    pkt_count  = '0;
    rssi_sum   = '0;
    mean_level = AVG_NONE;
  endfunction

  function automatic logic frame_passes(input logic [CH_W-1:0] ch,
                                        input logic signed [RSSI_W-1:0] rssi,
                                        input logic [MAC_W-1:0] src,
                                        input logic mgmt,
                                        input logic [SUBTYPE_W-1:0] sub);
    if (ch == '0 || rssi > 0) return 1'b0;
    if (mac_filter != '0 && src != mac_filter) return 1'b0;
    if (deauth_mode && !(mgmt && (sub == SUBTYPE_DISASSOC || sub == SUBTYPE_DEAUTH)))
      return 1'b0;
    return 1'b1;
  endfunction

  // Updates the shadow state for one transaction and queues the reports it causes.
  function automatic void predict_reports(input logic [OP_W-1:0] op,
                                          input logic [CH_W-1:0] ch,
                                          input logic signed [RSSI_W-1:0] rssi,
                                          input logic [MAC_W-1:0] src,
                                          input logic mgmt,
                                          input logic [SUBTYPE_W-1:0] sub);
    report_t rep;
    logic    ok;
    longint  quotient;
    int      clamped;
    rep = '0;
    case (op)
      OP_PACKET: begin
        ok = frame_passes(ch, rssi, src, mgmt, sub);
        if (ok) begin
          // A saturated count freezes both count and sum, so the sum never
          // gets near the bottom of its range.
          if (pkt_count != '1) begin
            pkt_count = pkt_count + 1'b1;
            rssi_sum  = rssi_sum + rssi;
          end
          quotient   = longint'(rssi_sum) / longint'({1'b0, pkt_count});
          mean_level = AVG_W'(quotient);
          if (ch <= NUM_CHANNELS) begin
            clamped = mean_level;
            if (clamped < int'(LVL_MIN)) clamped = int'(LVL_MIN);
            if (clamped > int'(LVL_MAX)) clamped = int'(LVL_MAX);
            levels[ch - 1'b1] = LVL_W'(clamped - int'(LVL_MIN));
          end
        end
        rep.accepted = ok;
        rep.total    = pkt_count;
        rep.avg      = mean_level;
        rep.last     = 1'b1;
        pending_reports.push_back(rep);
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          levels[i] = LVL_W'((int'(levels[i]) * 9) / 10);
          rep      = '0;
          rep.kind = 1'b1;
          rep.ch   = CH_W'(i + 1);
          rep.lvl  = levels[i];
          rep.last = (i == NUM_CHANNELS - 1);
          pending_reports.push_back(rep);
        end
        if (!scan_mode) restart_stats();
      end
      OP_CLEAR: begin
        restart_stats();
        rep.total = pkt_count;
        rep.avg   = mean_level;
        rep.last  = 1'b1;
        pending_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input report_t want,
                                        input report_t got);
    mismatch_total++;
    if (mismatch_total <= SHOWN_MISMATCHES) begin
      $display("[wrcm_checker] %0s at %0t", what, $time);
      $display("  expected kind=%0d acc=%0d total=%0d avg=%0d ch=%0d lvl=%0d last=%0d",
               want.kind, want.accepted, want.total, want.avg, want.ch, want.lvl,
               want.last);
      $display("  actual   kind=%0d acc=%0d total=%0d avg=%0d ch=%0d lvl=%0d last=%0d",
               got.kind, got.accepted, got.total, got.avg, got.ch, got.lvl, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      mac_filter  = '0;
      deauth_mode = 1'b0;
      scan_mode   = 1'b1;
      restart_stats();
      for (int i = 0; i < NUM_CHANNELS; i++) levels[i] = '0;
      pending_reports.delete();
    end else begin
      // Results are checked before new transactions are predicted, so a result
      // can never be matched against an item accepted at the same edge.
      if (result_mon.valid && result_mon.ready) begin
        got = {result_mon.kind, result_mon.accepted, result_mon.packet_total,
               result_mon.average_rssi, result_mon.hist_channel,
               result_mon.hist_level, result_mon.last};
        if (pending_reports.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = pending_reports.pop_front();
          if (got.kind !== want.kind || got.accepted !== want.accepted ||
              got.total !== want.total || got.avg !== want.avg ||
              got.ch !== want.ch || got.lvl !== want.lvl || got.last !== want.last)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (item_mon.valid && item_mon.ready)
        predict_reports(item_mon.op, item_mon.channel, item_mon.rssi,
                        item_mon.source_mac, item_mon.is_management,
                        item_mon.frame_subtype);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET_MAC:   mac_filter  = cfg_data_i;
          CFG_DEAUTH_ONLY:  deauth_mode = cfg_data_i[0];
          CFG_AUTO_CHANNEL: scan_mode   = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatch_total;
    outstanding_o    <= pending_reports.size();
  end

endmodule

[test/wifi_rssi_channel_monitor_unit_tb.sv]
module wifi_rssi_channel_monitor_unit_tb;
  import wrcm_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 9;
  // The limit leaves room for the slowest correct run: every refresh
  // tick waiting out long receiver stalls on all of its histogram entries.
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Covers any work still in flight, such as a counted packet still
  // passing through the divider.
  localparam int SETTLE_CYCLES   = 60;
  localparam int PRESSURE_CYCLES = 400;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_ITEMS     = 36;
  // The block ignores this operation code without answering.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [CH_W-1:0]          channel;
    logic signed [RSSI_W-1:0] rssi;
    logic [MAC_W-1:0]         src;
    logic                     mgmt;
    logic [SUBTYPE_W-1:0]     subtype;
  } frame_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [MAC_W-1:0]     cfg_data_i;
  int unsigned          mismatches;
  int unsigned          outstanding;
  int unsigned          cycle_count = 0;

  // Idling controls shared by the sender and the receiver processes.
  bit tx_idles;
  bit rx_stalls;
  bit pressure_req;

  // Mirror of the filter settings, used to shape frames that pass them.
  logic [MAC_W-1:0] cur_target;
  logic             cur_deauth;

  wrcm_pkt_if item_if ();
  wrcm_res_if result_if ();

  wifi_rssi_channel_monitor_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  // The checker watches both channels and the register port, predicts every
  // result and reports how many failed and how many are still outstanding.
  wrcm_result_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .item_mon         (item_if),
    .result_mon       (result_if),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // A hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[wifi_rssi_channel_monitor_unit] ERROR");
      $finish;
    end
  end

  function automatic frame_item_t frame(input logic [OP_W-1:0] op, input int ch,
                                        input int rssi, input logic [MAC_W-1:0] src,
                                        input logic mgmt, input int sub);
    frame_item_t it;
    it.op      = op;
    it.channel = CH_W'(ch);
    it.rssi    = RSSI_W'(rssi);
    it.src     = src;
    it.mgmt    = mgmt;
    it.subtype = SUBTYPE_W'(sub);
    return it;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), $urandom};
  endfunction

  // Mostly frames that pass the current filters, so the averages and the
  // histogram move; the rest are dropped frames, ticks, clears and noise.
  function automatic frame_item_t random_frame();
    frame_item_t it;
    int pick;
    int band;
    it = frame(OP_PACKET, 0, 0, random_mac(), 1'($urandom), $urandom_range(0, 15));
    it.channel = CH_W'($urandom_range(0, 15));
    it.rssi    = RSSI_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.op = OP_TICK;
    end else if (pick < 16) begin
      it.op = OP_CLEAR;
    end else if (pick < 19) begin
      it.op = OP_UNUSED;
    end else begin
      if ($urandom_range(0, 99) < 94) it.channel = CH_W'($urandom_range(1, 15));
      band = $urandom_range(0, 99);
      if (band < 8) begin
        it.rssi = RSSI_W'($urandom_range(1, 127));
      end else if (band < 38) begin
        it.rssi = RSSI_W'(-int'($urandom_range(0, 30)));
      end else if (band < 58) begin
        it.rssi = RSSI_W'(-int'($urandom_range(85, 128)));
      end else begin
        it.rssi = RSSI_W'(-int'($urandom_range(10, 100)));
      end
      if (cur_target != '0 && $urandom_range(0, 99) < 85) it.src = cur_target;
      if (cur_deauth && $urandom_range(0, 99) < 75) begin
        it.mgmt    = 1'b1;
        it.subtype = $urandom_range(0, 1) ? SUBTYPE_DISASSOC : SUBTYPE_DEAUTH;
      end
    end
    return it;
  endfunction

  // Offers one transaction, holds it until the block takes it, then idles for
  // a random gap. With no gap valid simply stays high for the next item.
  task automatic send_frame(input frame_item_t it);
    int gap;
    int pick;
    item_if.valid         <= 1'b1;
    item_if.op            <= it.op;
    item_if.channel       <= it.channel;
    item_if.rssi          <= it.rssi;
    item_if.source_mac    <= it.src;
    item_if.is_management <= it.mgmt;
    item_if.frame_subtype <= it.subtype;
    do @(posedge clk_i); while (!item_if.ready);
    gap = 0;
    if (tx_idles) begin
      pick = $urandom_range(0, 99);
      if (pick >= 55) gap = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 45);
    end
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every predicted result has come back and the block has had
  // time to finish any item that answers nothing.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles; the enable stays high
  // across the burst so it is never lowered and raised in the same step.
  task automatic apply_settings(input logic [MAC_W-1:0] mac, input logic deauth,
                                input logic scan);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TARGET_MAC;
    cfg_data_i <= mac;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DEAUTH_ONLY;
    cfg_data_i <= MAC_W'(deauth);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_AUTO_CHANNEL;
    cfg_data_i <= MAC_W'(scan);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_target = mac;
    cur_deauth = deauth;
  endtask

  // The receiver: random stalls, mostly short, and one long hold-off on
  // request, during which the sender keeps offering items.
  initial begin
    int hold;
    hold = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        result_if.ready <= 1'b0;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold = PRESSURE_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else if (rst_ni && rx_stalls && $urandom_range(0, 99) < 25) begin
        hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(15, 60);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    frame_item_t it;
    int sent;
    logic [MAC_W-1:0] mac;
    tx_idles     = 1'b0;
    rx_stalls    = 1'b0;
    pressure_req = 1'b0;
    cur_target   = '0;
    cur_deauth   = 1'b0;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_TARGET_MAC;
    cfg_data_i            <= '0;
    item_if.valid         <= 1'b0;
    item_if.op            <= OP_PACKET;
    item_if.channel       <= '0;
    item_if.rssi          <= '0;
    item_if.source_mac    <= '0;
    item_if.is_management <= 1'b0;
    item_if.frame_subtype <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings, back to back on both sides.
    // Channel one at zero dBm clamps the level to the top of the scale.
    send_frame(frame(OP_PACKET, 1, 0, '0, 1'b0, 0));
    send_frame(frame(OP_PACKET, 14, -128, MAC_ALL_ONES, 1'b1, 15));
    // A channel above the table is counted but leaves the histogram alone.
    send_frame(frame(OP_PACKET, 15, -50, 48'h1234_5678_9ABC, 1'b0, 0));
    // Channel zero and any positive RSSI are dropped.
    send_frame(frame(OP_PACKET, 0, -40, '0, 1'b0, 0));
    send_frame(frame(OP_PACKET, 3, 1, '0, 1'b0, 0));
    send_frame(frame(OP_PACKET, 2, 127, '0, 1'b0, 0));
    send_frame(frame(OP_TICK, 0, 0, '0, 1'b0, 0));
    send_frame(frame(OP_CLEAR, 15, -1, MAC_ALL_ONES, 1'b1, 15));
    // A lone -128 dBm frame clamps the level to the bottom of the scale.
    send_frame(frame(OP_PACKET, 5, -128, '0, 1'b0, 0));
    send_frame(frame(OP_PACKET, 6, -20, '0, 1'b0, 0));
    send_frame(frame(OP_UNUSED, 7, -60, MAC_ALL_ONES, 1'b1, 12));
    send_frame(frame(OP_TICK, 15, 127, MAC_ALL_ONES, 1'b1, 15));
    send_frame(frame(OP_PACKET, 7, -90, 48'h0000_0000_0001, 1'b1, 15));
    wait_idle();

    // Directed filter checks: all-ones target, deauth-only mode, and ticks
    // that clear the statistics.
    apply_settings(MAC_ALL_ONES, 1'b1, 1'b0);
    send_frame(frame(OP_PACKET, 1, -30, MAC_ALL_ONES, 1'b1, SUBTYPE_DISASSOC));
    send_frame(frame(OP_PACKET, 2, -40, MAC_ALL_ONES, 1'b1, SUBTYPE_DEAUTH));
    send_frame(frame(OP_PACKET, 3, -50, MAC_ALL_ONES, 1'b0, SUBTYPE_DISASSOC));
    send_frame(frame(OP_PACKET, 4, -50, MAC_ALL_ONES, 1'b1, 11));
    send_frame(frame(OP_PACKET, 5, -50, 48'hFFFF_FFFF_FFFE, 1'b1, SUBTYPE_DISASSOC));
    send_frame(frame(OP_TICK, 0, 0, '0, 1'b0, 0));
    send_frame(frame(OP_PACKET, 9, -60, MAC_ALL_ONES, 1'b1, SUBTYPE_DEAUTH));
    send_frame(frame(OP_CLEAR, 0, 0, '0, 1'b0, 0));

    // Random phases, each under its own settings, most with idling on both sides.
    tx_idles  = 1'b1;
    rx_stalls = 1'b1;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      mac = random_mac();
      if (mac == '0) mac = 48'h1;
      case (phase)
        0: apply_settings('0, 1'b0, 1'b1);
        1: apply_settings(mac, 1'b0, 1'b0);
        2: apply_settings('0, 1'b1, 1'b1);
        3: apply_settings(48'h1, 1'b1, 1'b0);
        default: apply_settings(mac, 1'b0, 1'b1);
      endcase
      // The third phase runs without any idling on either side.
      tx_idles  = (phase != 2);
      rx_stalls = (phase != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Early on, the receiver holds off long enough to back up the input.
        if (phase == 0 && sent == 12) pressure_req = 1'b1;
        it = random_frame();
        send_frame(it);
        if (it.op != OP_UNUSED) sent++;
      end
    end

    rx_stalls = 1'b0;
    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[wifi_rssi_channel_monitor_unit] OK");
    end else begin
      $display("[wifi_rssi_channel_monitor_unit] ERROR");
    end
    $finish;
  end

endmodule

[wifi_rssi_channel_monitor_unit.f]
src/wrcm_pkg.sv
src/wrcm_ifs.sv
src/wrcm_divider.sv
src/wrcm_level_table.sv
src/wifi_rssi_channel_monitor_unit.sv
test/wrcm_result_checker.sv
test/wifi_rssi_channel_monitor_unit_tb.sv
